// File: rtl/core/line_rasterizer_pixel_writer_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_RASTERIZER_PIXEL_WRITER_DEFINES_SVH
`define LINE_RASTERIZER_PIXEL_WRITER_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define LRPW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define LRPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lrpw_pkg.sv
package lrpw_pkg;

    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BITS_PER_PIXEL = 3'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [5:0]  BPP_32       = 6'd32;
    localparam logic [5:0]  BPP_24       = 6'd24;
    localparam logic [2:0]  BYTES_WORD   = 3'd4;
    localparam logic [2:0]  BYTES_TRIPLE = 3'd3;
    localparam logic [2:0]  BYTES_NONE   = 3'd0;
    localparam logic [31:0] COLOR_24_MASK = 32'h00FF_FFFF;

    // One pixel handed from the line engine to the writer.
    typedef struct packed {
        logic        active;  // pixel of a line in progress
        logic        done;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] color;
    } pixel_word_t;

endpackage

// File: rtl/core/line_rasterizer_pixel_writer.sv
// Bresenham line engine with framebuffer pixel writer. A start word latches
// both endpoints and the color and yields the first pixel; each step word yields
// the next one. Every accepted word gives exactly one result word, one word per
// clock sustained while in_stall is low; the line engine computes position and
// error term combinationally, so back-to-back steps never wait on it. A result
// is registered first in the two-entry queue between the line engine and the
// address unit, at the accepting edge, then in the output register once output
// stall lets the queue entry go. The address unit forms base + y*pitch + x*bytes
// with one multiply of y by the 16-bit pitch, ahead of the output register.
// in_stall rises only when the queue is full, which output stall alone causes.
// Configuration writes belong to idle periods.
module line_rasterizer_pixel_writer
    import lrpw_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int ADDR_BITS = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic signed [15:0]        start_x,
    input  logic signed [15:0]        start_y,
    input  logic signed [15:0]        end_x,
    input  logic signed [15:0]        end_y,
    input  logic [31:0]               color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      write_enable,
    output logic [ADDR_BITS-1:0]      byte_address,
    output logic [31:0]               pixel_data,
    output logic [2:0]                byte_count,
    output logic                      pixel_valid,
    output logic                      line_done
);

    pixel_word_t front_word, head_word;
    logic        q_full, q_not_empty;
    logic        accept, take;
    logic        out_valid_reg, out_valid_next;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign take     = q_not_empty && (!out_valid_reg || !out_stall);

    lrpw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .color   (color),
        .word    (front_word)
    );

    lrpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_word),
        .pop       (take),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    lrpw_back #(
        .MAX_DIM   (MAX_DIM),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .word         (head_word),
        .write_enable (write_enable),
        .byte_address (byte_address),
        .pixel_data   (pixel_data),
        .byte_count   (byte_count),
        .pixel_valid  (pixel_valid),
        .line_done    (line_done)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/lrpw_front.sv
module lrpw_front
    import lrpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               command,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic [31:0]        color,
    output pixel_word_t        word
);

    logic [15:0] cur_x_reg, cur_x_next;
    logic [15:0] cur_y_reg, cur_y_next;
    logic [15:0] tgt_x_reg, tgt_x_next;
    logic [15:0] tgt_y_reg, tgt_y_next;
    logic [15:0] dx_reg, dx_next;
    logic [15:0] dy_reg, dy_next;
    logic [1:0]  signs_reg, signs_next;
    logic [17:0] err_reg, err_next;
    logic [31:0] color_reg, color_next;
    logic        active_reg, active_next;

    logic signed [16:0] diff_x, diff_y;
    logic [15:0]        mag_x, mag_y;
    logic signed [18:0] e_ext, dx_ext, dy_ext, err_sum;
    logic               step_x, step_y, done;

    always_comb
    begin
        diff_x = 17'(end_x) - 17'(start_x);
        diff_y = 17'(end_y) - 17'(start_y);
        mag_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
        mag_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];

        e_ext   = 19'(signed'(err_reg));
        dx_ext  = signed'({3'b000, dx_reg});
        dy_ext  = signed'({3'b000, dy_reg});
        step_x  = e_ext > -dx_ext;
        step_y  = e_ext < dy_ext;
        err_sum = e_ext + (step_y ? dx_ext : 19'sd0) - (step_x ? dy_ext : 19'sd0);

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        signs_next  = signs_reg;
        err_next    = err_reg;
        color_next  = color_reg;

        if (command == CMD_START)
        begin
            cur_x_next = start_x;
            cur_y_next = start_y;
            tgt_x_next = end_x;
            tgt_y_next = end_y;
            dx_next    = mag_x;
            dy_next    = mag_y;
            signs_next = {!(start_y < end_y), !(start_x < end_x)};
            // initial error: dx/2 or -(dy/2), truncated toward zero
            err_next   = (mag_x > mag_y) ? {3'b000, mag_x[15:1]}
                                         : 18'(-{3'b000, mag_y[15:1]});
            color_next = color;
        end
        else if (active_reg)
        begin
            if (step_x)
                cur_x_next = signs_reg[0] ? cur_x_reg - 16'd1 : cur_x_reg + 16'd1;
            if (step_y)
                cur_y_next = signs_reg[1] ? cur_y_reg - 16'd1 : cur_y_reg + 16'd1;
            err_next = err_sum[17:0];
        end

        done        = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        active_next = active_reg;
        if (command == CMD_START || active_reg)
            active_next = !done;

        word.active = (command == CMD_START) || active_reg;
        word.done   = word.active && done;
        word.x      = cur_x_next;
        word.y      = cur_y_next;
        word.color  = color_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            signs_reg  <= '0;
            err_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            signs_reg  <= signs_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

endmodule

// File: rtl/core/lrpw_queue.sv
module lrpw_queue
    import lrpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pixel_word_t push_word,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output pixel_word_t head_word
);

    pixel_word_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_word = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/lrpw_back.sv
module lrpw_back
    import lrpw_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int ADDR_BITS = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      take,
    input  pixel_word_t               word,
    output logic                      write_enable,
    output logic [ADDR_BITS-1:0]      byte_address,
    output logic [31:0]               pixel_data,
    output logic [2:0]                byte_count,
    output logic                      pixel_valid,
    output logic                      line_done
);

    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int PROD_W = CW + 16;
    localparam int SUM_W = (ADDR_BITS > PROD_W + 1) ? ADDR_BITS : PROD_W + 1;
    localparam logic [15:0] DIM_LIM = 16'(MAX_DIM);

    logic [ADDR_BITS-1:0] base_reg;
    logic [12:0]          width_reg;
    logic [12:0]          height_reg;
    logic [15:0]          pitch_reg;
    logic [5:0]           bpp_reg;

    logic                 we_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [31:0]          data_reg;
    logic [2:0]           count_reg;
    logic                 valid_reg;
    logic                 done_reg;

    logic [15:0]          w_eff, h_eff;
    logic                 on_screen, we_next;
    logic [2:0]           bytes;
    logic [31:0]          data_sel;
    logic [PROD_W-1:0]    row_off;
    logic [CW+1:0]        col_off;
    logic [SUM_W-1:0]     addr_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            pitch_reg  <= '0;
            bpp_reg    <= BPP_32;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS:   base_reg   <= ADDR_BITS'(cfg_data);
                REG_SCREEN_WIDTH:   width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT:  height_reg <= cfg_data[12:0];
                REG_ROW_PITCH:      pitch_reg  <= cfg_data[15:0];
                REG_BITS_PER_PIXEL: bpp_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = ({3'b000, width_reg} > DIM_LIM) ? DIM_LIM : {3'b000, width_reg};
        h_eff = ({3'b000, height_reg} > DIM_LIM) ? DIM_LIM : {3'b000, height_reg};
        on_screen = !word.x[15] && !word.y[15] &&
                    ({1'b0, word.x[14:0]} < w_eff) && ({1'b0, word.y[14:0]} < h_eff);

        if (bpp_reg == BPP_32)
        begin
            bytes    = BYTES_WORD;
            data_sel = word.color;
        end
        else if (bpp_reg == BPP_24)
        begin
            bytes    = BYTES_TRIPLE;
            data_sel = word.color & COLOR_24_MASK;
        end
        else
        begin
            bytes    = BYTES_NONE;
            data_sel = '0;
        end

        we_next = word.active && on_screen && (bytes != BYTES_NONE);

        // x and y are below MAX_DIM whenever the write goes out
        row_off = PROD_W'(word.y[CW-1:0]) * PROD_W'(pitch_reg);
        col_off = (bpp_reg == BPP_32) ? {word.x[CW-1:0], 2'b00}
                                      : {1'b0, word.x[CW-1:0], 1'b0} + (CW+2)'(word.x[CW-1:0]);
        addr_sum = SUM_W'(base_reg) + SUM_W'(row_off) + SUM_W'(col_off);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            we_reg    <= we_next;
            addr_reg  <= we_next ? addr_sum[ADDR_BITS-1:0] : '0;
            data_reg  <= we_next ? data_sel : '0;
            count_reg <= we_next ? bytes : BYTES_NONE;
            valid_reg <= word.active;
            done_reg  <= word.done;
        end
    end

    assign write_enable = we_reg;
    assign byte_address = addr_reg;
    assign pixel_data   = data_reg;
    assign byte_count   = count_reg;
    assign pixel_valid  = valid_reg;
    assign line_done    = done_reg;

endmodule

// File: rtl/core/lrpw_checker.sv
`include "line_rasterizer_pixel_writer_defines.svh"

module lrpw_checker
    import lrpw_pkg::*;
#(
    parameter int ADDR_BITS = 48
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 write_enable,
    input logic [ADDR_BITS-1:0] byte_address,
    input logic [31:0]          pixel_data,
    input logic [2:0]           byte_count,
    input logic                 pixel_valid,
    input logic                 line_done
);

    // a write only comes from a live pixel and moves three or four bytes
    `LRPW_ASSERT_IMPL(a_write_sane, out_valid && write_enable, pixel_valid && (byte_count == BYTES_WORD || byte_count == BYTES_TRIPLE), "write without live pixel or bad byte count")
    // no write: address, data and count all read zero
    `LRPW_ASSERT_IMPL(a_nowrite_zero, out_valid && !write_enable, byte_count == BYTES_NONE && byte_address == '0 && pixel_data == '0, "suppressed write carries payload")
    // a step with no line in progress cannot finish a line
    `LRPW_ASSERT_IMPL(a_idle_step, out_valid && !pixel_valid, !line_done && !write_enable, "idle step flagged done or write")
    // 24 bpp leaves the top byte clear
    `LRPW_ASSERT_IMPL(a_triple_top, out_valid && byte_count == BYTES_TRIPLE, pixel_data[31:24] == 8'h00, "three-byte word has top byte set")
    `LRPW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(byte_address) && $stable(pixel_data), "stalled output word changed")

endmodule

bind line_rasterizer_pixel_writer lrpw_checker #(.ADDR_BITS(ADDR_BITS)) u_lrpw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .byte_address (byte_address),
    .pixel_data   (pixel_data),
    .byte_count   (byte_count),
    .pixel_valid  (pixel_valid),
    .line_done    (line_done)
);
